/* rtl/pkmt_pkg.sv */
`timescale 1ns / 1ps

package pkmt_pkg;

   localparam int MAX_RUNS_DEF    = 16;
   localparam int MAX_RUN_LEN_DEF = 64;
   localparam int DATA_WIDTH_DEF  = 32;

   localparam int VALUE_W      = 32;
   localparam int RUN_COUNT_W  = 5;
   localparam int RUN_LENGTH_W = 7;
   localparam int STATUS_W     = 2;
   localparam int CSR_AW       = 3;
   localparam int CSR_DW       = 32;

   localparam logic [RUN_COUNT_W-1:0]  RUN_COUNT_RST  = 5'd2;
   localparam logic [RUN_LENGTH_W-1:0] RUN_LENGTH_RST = 7'd64;

   localparam logic REG_RUN_COUNT  = 1'b0;
   localparam logic REG_RUN_LENGTH = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef enum logic {
      ACT_LOAD = 1'b0,
      ACT_PULL = 1'b1
   } action_type;

   typedef struct packed {
      logic       load_wr;
      logic       pull_rd;
      logic       merge_init;
      logic       level_next;
      logic       pair_init;
      logic       pair_mid;
      logic       pair_hi;
      logic       pair_next;
      logic       merge_wr;
      logic       merge_done;
      logic       rsp_load;
      logic       rsp_use_mem;
      status_type rsp_status;
   } cmd_type;

   typedef struct packed {
      logic load_ok;
      logic load_final;
      logic pull_ok;
      logic lvl_done;
      logic pairs_done;
      logic i_end;
      logic j_end;
      logic rsp_free;
   } stat_type;

endpackage

/* rtl/pairwise_kway_merge_tree.sv */
`timescale 1ns / 1ps
// One transaction in flight; a new one is taken once the result register is free.
// Load: result registered in the cycle after accept. Pull: memory output register, then result register.
// Final load of a batch runs the merge on two ping-pong memories, each element through a read and a write state;
//   per level each pair sets mid, then hi, then merges, and the result is loaded after the last level.
// Synchronous active-high reset clears counters, phase and result valid and sets
//   run_count 2, run_length 64; the element memories are not cleared.
module pairwise_kway_merge_tree #(
   parameter int MAX_RUNS    = pkmt_pkg::MAX_RUNS_DEF,
   parameter int MAX_RUN_LEN = pkmt_pkg::MAX_RUN_LEN_DEF,
   parameter int DATA_WIDTH  = pkmt_pkg::DATA_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [pkmt_pkg::VALUE_W-1:0]  req_tdata,   // value
   input  logic                          req_tuser,   // action
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [pkmt_pkg::VALUE_W-1:0]  rsp_tdata,   // merged_value
   output logic                          rsp_tlast,
   output logic [pkmt_pkg::STATUS_W-1:0] rsp_tuser,   // status
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [pkmt_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [pkmt_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [pkmt_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                          csr_pready
);
   import pkmt_pkg::*;

   cmd_type  cmd;
   stat_type stat;
   logic     csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   pkmt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_action (req_tuser),
      .stat       (stat),
      .cmd        (cmd)
   );

   pkmt_dpath #(
      .MAX_RUNS    (MAX_RUNS),
      .MAX_RUN_LEN (MAX_RUN_LEN),
      .DATA_WIDTH  (DATA_WIDTH)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .csr_wr     (csr_wr),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .req_value  (req_tdata),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_value  (rsp_tdata),
      .rsp_last   (rsp_tlast),
      .rsp_status (rsp_tuser)
   );

endmodule

/* rtl/pkmt_ctrl.sv */
`timescale 1ns / 1ps

module pkmt_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic               req_action,
   input  pkmt_pkg::stat_type stat,
   output pkmt_pkg::cmd_type  cmd
);
   import pkmt_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PULL_WAIT,
      ST_LEVEL,
      ST_PAIR,
      ST_HI,
      ST_READ,
      ST_WRITE
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_tready = (state_ff == ST_IDLE) && stat.rsp_free;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      cmd        = '0;
      cmd.rsp_status = STATUS_OK;
      state_in   = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (action_type'(req_action) == ACT_LOAD) begin
                  if (!stat.load_ok) begin
                     cmd.rsp_load   = 1'b1;
                     cmd.rsp_status = STATUS_FULL;
                  end else begin
                     cmd.load_wr = 1'b1;
                     if (stat.load_final) begin
                        cmd.merge_init = 1'b1;
                        state_in       = ST_LEVEL;
                     end else begin
                        cmd.rsp_load = 1'b1;
                     end
                  end
               end else begin
                  if (!stat.pull_ok) begin
                     cmd.rsp_load   = 1'b1;
                     cmd.rsp_status = STATUS_EMPTY;
                  end else begin
                     cmd.pull_rd = 1'b1;
                     state_in    = ST_PULL_WAIT;
                  end
               end
            end
         end
         ST_PULL_WAIT: begin
            cmd.rsp_load    = 1'b1;
            cmd.rsp_use_mem = 1'b1;
            state_in        = ST_IDLE;
         end
         ST_LEVEL: begin
            if (stat.lvl_done) begin
               cmd.merge_done = 1'b1;
               cmd.rsp_load   = 1'b1;
               state_in       = ST_IDLE;
            end else begin
               cmd.pair_init = 1'b1;
               state_in      = ST_PAIR;
            end
         end
         ST_PAIR: begin
            if (stat.pairs_done) begin
               cmd.level_next = 1'b1;
               state_in       = ST_LEVEL;
            end else begin
               cmd.pair_mid = 1'b1;
               state_in     = ST_HI;
            end
         end
         ST_HI: begin
            cmd.pair_hi = 1'b1;
            state_in    = ST_READ;
         end
         ST_READ: begin
            if (stat.i_end && stat.j_end) begin
               cmd.pair_next = 1'b1;
               state_in      = ST_PAIR;
            end else begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            cmd.merge_wr = 1'b1;
            state_in     = ST_READ;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* rtl/pkmt_dpath.sv */
`timescale 1ns / 1ps

module pkmt_dpath #(
   parameter int MAX_RUNS    = pkmt_pkg::MAX_RUNS_DEF,
   parameter int MAX_RUN_LEN = pkmt_pkg::MAX_RUN_LEN_DEF,
   parameter int DATA_WIDTH  = pkmt_pkg::DATA_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr,
   input  logic [pkmt_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [pkmt_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [pkmt_pkg::CSR_DW-1:0]   csr_prdata,
   input  logic [pkmt_pkg::VALUE_W-1:0]  req_value,
   input  pkmt_pkg::cmd_type             cmd,
   output pkmt_pkg::stat_type            stat,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [pkmt_pkg::VALUE_W-1:0]  rsp_value,
   output logic                          rsp_last,
   output logic [pkmt_pkg::STATUS_W-1:0] rsp_status
);
   import pkmt_pkg::*;

   localparam int DEPTH = MAX_RUNS * MAX_RUN_LEN;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(DEPTH + 1);
   localparam int PW    = CW + 1;
   localparam int RW    = $clog2(MAX_RUNS + 1);
   localparam int LW    = $clog2(MAX_RUN_LEN + 1);

   logic [RUN_COUNT_W-1:0]  run_count_ff, run_count_in;
   logic [RUN_LENGTH_W-1:0] run_length_ff, run_length_in;
   logic [CW-1:0]           lc_ff, lc_in, rp_ff, rp_in;
   logic                    ready_ff, ready_in;
   logic                    last_pend_ff, last_pend_in;
   logic                    sel_ff, sel_in;
   logic [PW-1:0]           width_ff, width_in, lo_ff, lo_in, mid_ff, mid_in;
   logic [PW-1:0]           hi_ff, hi_in, i_ff, i_in, j_ff, j_in, o_ff, o_in;
   logic                    rsp_valid_ff, rsp_valid_in, rsp_last_ff, rsp_last_in;
   logic [VALUE_W-1:0]      rsp_value_ff, rsp_value_in;
   status_type              rsp_status_ff, rsp_status_in;

   logic [DATA_WIDTH-1:0]   mem0 [DEPTH];
   logic [DATA_WIDTH-1:0]   mem1 [DEPTH];
   logic [DATA_WIDTH-1:0]   rd0a_ff, rd0b_ff, rd1a_ff, rd1b_ff;
   logic [DATA_WIDTH-1:0]   rd_a, rd_b, wr_data, load_data;
   logic [AW-1:0]           wr_addr, rd_addr_a, rd_addr_b;
   logic                    we0, we1;

   logic [RW-1:0]           eff_runs;
   logic [LW-1:0]           eff_len;
   logic [CW-1:0]           total;
   logic [PW-1:0]           total_p, sum_mid, sum_hi;
   logic                    take_left, pull_final;
   logic [DATA_WIDTH+VALUE_W-1:0] load_ext, out_ext;

   always_comb begin
      if (run_count_ff == '0) begin
         eff_runs = RW'(1);
      end else if (int'(run_count_ff) > MAX_RUNS) begin
         eff_runs = RW'(MAX_RUNS);
      end else begin
         eff_runs = RW'(run_count_ff);
      end
      if (run_length_ff == '0) begin
         eff_len = LW'(1);
      end else if (int'(run_length_ff) > MAX_RUN_LEN) begin
         eff_len = LW'(MAX_RUN_LEN);
      end else begin
         eff_len = LW'(run_length_ff);
      end
   end

   assign total   = CW'(eff_runs) * CW'(eff_len);
   assign total_p = PW'(total);
   assign sum_mid = lo_ff + width_ff;
   assign sum_hi  = mid_ff + width_ff;

   assign rd_a = sel_ff ? rd1a_ff : rd0a_ff;
   assign rd_b = sel_ff ? rd1b_ff : rd0b_ff;

   assign stat.load_ok    = !ready_ff && (lc_ff < total);
   assign stat.load_final = (lc_ff + CW'(1)) == total;
   assign stat.pull_ok    = ready_ff && (rp_ff < total);
   assign stat.lvl_done   = width_ff >= total_p;
   assign stat.pairs_done = lo_ff >= total_p;
   assign stat.i_end      = i_ff >= mid_ff;
   assign stat.j_end      = j_ff >= hi_ff;
   assign stat.rsp_free   = !rsp_valid_ff || rsp_tready;

   assign take_left  = !stat.i_end && (stat.j_end || ($signed(rd_a) <= $signed(rd_b)));
   assign pull_final = (rp_ff + CW'(1)) == total;

   assign load_ext  = {{DATA_WIDTH{1'b0}}, req_value};
   assign load_data = load_ext[DATA_WIDTH-1:0];
   assign out_ext   = {{VALUE_W{1'b0}}, rd_a};

   assign wr_data   = cmd.load_wr ? load_data : (take_left ? rd_a : rd_b);
   assign wr_addr   = cmd.load_wr ? lc_ff[AW-1:0] : o_ff[AW-1:0];
   assign we0       = cmd.load_wr || (cmd.merge_wr && sel_ff);
   assign we1       = cmd.merge_wr && !sel_ff;
   assign rd_addr_a = cmd.pull_rd ? rp_ff[AW-1:0] : i_ff[AW-1:0];
   assign rd_addr_b = j_ff[AW-1:0];

   always_ff @(posedge clock) begin
      if (we0) begin
         mem0[wr_addr] <= wr_data;
      end
      rd0a_ff <= mem0[rd_addr_a];
      rd0b_ff <= mem0[rd_addr_b];
   end

   always_ff @(posedge clock) begin
      if (we1) begin
         mem1[wr_addr] <= wr_data;
      end
      rd1a_ff <= mem1[rd_addr_a];
      rd1b_ff <= mem1[rd_addr_b];
   end

   always_comb begin
      run_count_in  = run_count_ff;
      run_length_in = run_length_ff;
      lc_in         = lc_ff;
      rp_in         = rp_ff;
      ready_in      = ready_ff;
      last_pend_in  = last_pend_ff;
      sel_in        = sel_ff;
      width_in      = width_ff;
      lo_in         = lo_ff;
      mid_in        = mid_ff;
      hi_in         = hi_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      o_in          = o_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_status_in = rsp_status_ff;

      if (csr_wr) begin
         unique case (csr_paddr[2])
            REG_RUN_COUNT:  run_count_in  = csr_pwdata[RUN_COUNT_W-1:0];
            REG_RUN_LENGTH: run_length_in = csr_pwdata[RUN_LENGTH_W-1:0];
            default: ;
         endcase
         lc_in    = '0;
         rp_in    = '0;
         ready_in = 1'b0;
      end else begin
         if (cmd.load_wr) begin
            lc_in = lc_ff + CW'(1);
         end
         if (cmd.pull_rd) begin
            rp_in        = rp_ff + CW'(1);
            last_pend_in = pull_final;
            if (pull_final) begin
               lc_in    = '0;
               rp_in    = '0;
               ready_in = 1'b0;
            end
         end
         if (cmd.merge_done) begin
            rp_in    = '0;
            ready_in = 1'b1;
         end
      end

      if (cmd.merge_init) begin
         sel_in   = 1'b0;
         width_in = PW'(eff_len);
      end
      if (cmd.level_next) begin
         sel_in   = !sel_ff;
         width_in = width_ff << 1;
      end
      if (cmd.pair_init) begin
         lo_in = '0;
      end
      if (cmd.pair_mid) begin
         mid_in = (sum_mid > total_p) ? total_p : sum_mid;
         i_in   = lo_ff;
         o_in   = lo_ff;
      end
      if (cmd.pair_hi) begin
         hi_in = (sum_hi > total_p) ? total_p : sum_hi;
         j_in  = mid_ff;
      end
      if (cmd.pair_next) begin
         lo_in = hi_ff;
      end
      if (cmd.merge_wr) begin
         o_in = o_ff + PW'(1);
         if (take_left) begin
            i_in = i_ff + PW'(1);
         end else begin
            j_in = j_ff + PW'(1);
         end
      end

      if (cmd.rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = cmd.rsp_status;
         rsp_value_in  = cmd.rsp_use_mem ? out_ext[VALUE_W-1:0] : '0;
         rsp_last_in   = cmd.rsp_use_mem && last_pend_ff;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_count_ff  <= RUN_COUNT_RST;
         run_length_ff <= RUN_LENGTH_RST;
         lc_ff         <= '0;
         rp_ff         <= '0;
         ready_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         run_count_ff  <= run_count_in;
         run_length_ff <= run_length_in;
         lc_ff         <= lc_in;
         rp_ff         <= rp_in;
         ready_ff      <= ready_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      last_pend_ff  <= last_pend_in;
      sel_ff        <= sel_in;
      width_ff      <= width_in;
      lo_ff         <= lo_in;
      mid_ff        <= mid_in;
      hi_ff         <= hi_in;
      i_ff          <= i_in;
      j_ff          <= j_in;
      o_ff          <= o_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_RUN_COUNT:  csr_prdata = CSR_DW'(run_count_ff);
         REG_RUN_LENGTH: csr_prdata = CSR_DW'(run_length_ff);
         default:        csr_prdata = '0;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_last   = rsp_last_ff;
   assign rsp_status = rsp_status_ff;

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps

module testbench;
   import pkmt_pkg::*;

   localparam int WATCHDOG_LIMIT = 40000;
   localparam int LONG_HOLD      = 300;
   localparam int ITEM_BUDGET    = 2400;
   localparam int STORE_DEPTH    = MAX_RUNS_DEF * MAX_RUN_LEN_DEF;

   typedef enum logic {
      BATCH_LOADING,
      BATCH_READY
   } batch_phase_type;

   typedef struct {
      action_type          act;
      logic [VALUE_W-1:0]  value;
   } load_pull_type;

   typedef struct {
      logic [VALUE_W-1:0]  value;
      logic                last;
      status_type          status;
   } merged_out_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [VALUE_W-1:0]   req_tdata = '0;   // value
   logic                 req_tuser = 1'b0; // action
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [VALUE_W-1:0]   rsp_tdata;        // merged_value
   logic                 rsp_tlast;
   logic [STATUS_W-1:0]  rsp_tuser;        // status
   logic                 csr_psel = 1'b0;
   logic                 csr_penable = 1'b0;
   logic                 csr_pwrite = 1'b0;
   logic [CSR_AW-1:0]    csr_paddr = '0;
   logic [CSR_DW-1:0]    csr_pwdata = '0;
   logic [CSR_DW-1:0]    csr_prdata;
   logic                 csr_pready;

   // predictor state
   logic signed [VALUE_W-1:0] batch_vals [0:STORE_DEPTH-1];
   logic signed [VALUE_W-1:0] merge_tmp [0:STORE_DEPTH-1];
   int                        load_cnt = 0;
   int                        rd_ptr = 0;
   batch_phase_type           batch_phase = BATCH_LOADING;
   logic [RUN_COUNT_W-1:0]    cfg_runs = RUN_COUNT_RST;
   logic [RUN_LENGTH_W-1:0]   cfg_len = RUN_LENGTH_RST;

   load_pull_type   load_pull_queue [$];
   merged_out_type  pending_merge_out [$];
   load_pull_type   next_item;
   merged_out_type  want;

   int send_gap = 0;
   int recv_gap = 0;
   int tx_calm = 0;
   int rx_calm = 0;
   int quiet_cycles = 0;
   int queued_items = 0;
   int loads_accepted = 0;
   int pulls_accepted = 0;
   int results_seen = 0;
   int mismatches = 0;
   int batches_merged = 0;
   int ok_count = 0;
   int full_count = 0;
   int empty_count = 0;
   int csr_writes = 0;

   pairwise_kway_merge_tree dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int active_runs();
      if (cfg_runs == 0) return 1;
      return (cfg_runs > MAX_RUNS_DEF) ? MAX_RUNS_DEF : int'(cfg_runs);
   endfunction

   function automatic int active_len();
      if (cfg_len == 0) return 1;
      return (cfg_len > MAX_RUN_LEN_DEF) ? MAX_RUN_LEN_DEF : int'(cfg_len);
   endfunction

   // level-by-level pairwise merge, left side wins ties, odd run carried through
   function automatic void merge_runs(input int total, input int width);
      int w, lo, mid, hi, i, j, o;
      w = width;
      while (w < total) begin
         lo = 0;
         while (lo < total) begin
            mid = (lo + w > total) ? total : lo + w;
            hi = (mid + w > total) ? total : mid + w;
            i = lo;
            j = mid;
            o = lo;
            while (i < mid && j < hi) begin
               if (batch_vals[i] <= batch_vals[j]) begin
                  merge_tmp[o] = batch_vals[i];
                  i++;
               end else begin
                  merge_tmp[o] = batch_vals[j];
                  j++;
               end
               o++;
            end
            while (i < mid) begin
               merge_tmp[o] = batch_vals[i];
               i++;
               o++;
            end
            while (j < hi) begin
               merge_tmp[o] = batch_vals[j];
               j++;
               o++;
            end
            lo = hi;
         end
         for (int k = 0; k < total; k++) batch_vals[k] = merge_tmp[k];
         w = w * 2;
      end
   endfunction

   function automatic void predict_merge_step(input action_type act,
                                              input logic [VALUE_W-1:0] v);
      merged_out_type r;
      int total;
      total = active_runs() * active_len();
      r.value = '0;
      r.last = 1'b0;
      r.status = STATUS_OK;
      if (act == ACT_LOAD) begin
         if (batch_phase != BATCH_LOADING || load_cnt >= total) begin
            r.status = STATUS_FULL;
         end else begin
            batch_vals[load_cnt] = v;
            load_cnt++;
            if (load_cnt == total) begin
               merge_runs(total, active_len());
               rd_ptr = 0;
               batch_phase = BATCH_READY;
               batches_merged++;
            end
         end
      end else begin
         if (batch_phase != BATCH_READY || rd_ptr >= total) begin
            r.status = STATUS_EMPTY;
         end else begin
            r.value = batch_vals[rd_ptr];
            rd_ptr++;
            if (rd_ptr == total) begin
               r.last = 1'b1;
               load_cnt = 0;
               rd_ptr = 0;
               batch_phase = BATCH_LOADING;
            end
         end
      end
      case (r.status)
         STATUS_OK:   ok_count++;
         STATUS_FULL: full_count++;
         default:     empty_count++;
      endcase
      pending_merge_out.push_back(r);
   endfunction

   function automatic int pick_gap(inout int calm);
      int r;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 2) begin
         calm = $urandom_range(20, 80);
         return 0;
      end
      if (r < 50) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic int pick_value(input int style);
      case (style)
         0: return int'($urandom_range(0, 16)) - 8;
         1: begin
            case ($urandom_range(0, 4))
               0: return int'(32'h8000_0000);
               1: return int'(32'h7FFF_FFFF);
               2: return 0;
               3: return -1;
               default: return int'($urandom());
            endcase
         end
         2: return int'($urandom()) >>> $urandom_range(0, 31);
         default: return int'($urandom());
      endcase
   endfunction

   function automatic void queue_item(input action_type act, input logic [VALUE_W-1:0] v);
      load_pull_type it;
      it.act = act;
      it.value = v;
      load_pull_queue.push_back(it);
      queued_items++;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_merge_step(action_type'(req_tuser), req_tdata);
            if (req_tuser == ACT_PULL) pulls_accepted++;
            else loads_accepted++;
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap == 0 && load_pull_queue.size() != 0) begin
               next_item = load_pull_queue.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= next_item.value;
               req_tuser <= next_item.act;
               send_gap = pick_gap(tx_calm);
            end else begin
               req_tvalid <= 1'b0;
               if (send_gap > 0) send_gap--;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_gap = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (pending_merge_out.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: response with nothing pending: value %h last %b status %0d",
                           $time, rsp_tdata, rsp_tlast, rsp_tuser);
            end else begin
               want = pending_merge_out.pop_front();
               if (rsp_tdata !== want.value || rsp_tlast !== want.last ||
                   rsp_tuser !== want.status) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%0t: mismatch: got %h/%b/%0d, expected %h/%b/%0d",
                              $time, rsp_tdata, rsp_tlast, rsp_tuser,
                              want.value, want.last, want.status);
               end
            end
            // long back-pressure stretch while the sender keeps offering
            recv_gap = (results_seen % 1000 == 150) ? LONG_HOLD : pick_gap(rx_calm);
         end
         if (recv_gap > 0) begin
            recv_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("[pairwise_kway_merge_tree] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic wait_idle();
      do @(negedge clock);
      while (load_pull_queue.size() != 0 || req_tvalid || pending_merge_out.size() != 0);
   endtask

   task automatic write_csr(input logic idx, input int field);
      logic [CSR_DW-1:0] word;
      word = $urandom_range(0, 1) ? $urandom() : '0;
      if (idx == REG_RUN_COUNT) word[RUN_COUNT_W-1:0] = field[RUN_COUNT_W-1:0];
      else word[RUN_LENGTH_W-1:0] = field[RUN_LENGTH_W-1:0];
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_AW'({idx, 2'b00});
      csr_pwdata <= word;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (idx == REG_RUN_COUNT) cfg_runs = word[RUN_COUNT_W-1:0];
      else cfg_len = word[RUN_LENGTH_W-1:0];
      load_cnt = 0;
      rd_ptr = 0;
      batch_phase = BATCH_LOADING;
      csr_writes++;
      @(negedge clock);
   endtask

   task automatic fill_batch(input bit pause_mid, input bit abort);
      int total, len, cut, loaded, style;
      int run_vals [$];
      total = active_runs() * active_len();
      len = active_len();
      cut = abort ? $urandom_range(0, total - 1) : total;
      loaded = 0;
      if ($urandom_range(0, 3) == 0) queue_item(ACT_PULL, $urandom());
      for (int r = 0; r < active_runs(); r++) begin
         style = $urandom_range(0, 3);
         run_vals.delete();
         for (int k = 0; k < len; k++) run_vals.push_back(pick_value(style));
         if ($urandom_range(0, 9) != 0) run_vals.sort();
         foreach (run_vals[k]) begin
            if (loaded == cut) return;
            queue_item(ACT_LOAD, run_vals[k]);
            loaded++;
            if ($urandom_range(0, 29) == 0 && loaded < total) queue_item(ACT_PULL, $urandom());
            if (pause_mid && loaded == total / 2) wait_idle();
         end
      end
      if ($urandom_range(0, 3) == 0) queue_item(ACT_LOAD, $urandom());
      for (int p = 0; p < total; p++) begin
         queue_item(ACT_PULL, $urandom());
         if ($urandom_range(0, 29) == 0 && p < total - 1) queue_item(ACT_LOAD, $urandom());
      end
      if ($urandom_range(0, 3) == 0) queue_item(ACT_PULL, $urandom());
   endtask

   task automatic run_phase(input int runs, input int len, input bit set_runs,
                            input bit set_len, input bit pause_mid, input bit abort);
      if (set_runs || set_len) begin
         wait_idle();
         if (set_runs) write_csr(REG_RUN_COUNT, runs);
         if (set_len) write_csr(REG_RUN_LENGTH, len);
      end
      fill_batch(pause_mid, abort);
   endtask

   initial begin
      int runs, len, sel;
      bit abort, restart_due, set_runs, set_len;

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset configuration: early pull, then a partial batch
      queue_item(ACT_PULL, 32'hFFFF_FFFF);
      queue_item(ACT_LOAD, 32'h8000_0000);
      queue_item(ACT_LOAD, 32'h7FFF_FFFF);
      wait_idle();

      // three runs of two: odd run carried through the levels
      write_csr(REG_RUN_COUNT, 3);
      write_csr(REG_RUN_LENGTH, 2);
      queue_item(ACT_LOAD, 32'hFFFF_FFFF);
      queue_item(ACT_LOAD, 32'h0000_0005);
      queue_item(ACT_PULL, 32'h0000_0000);
      queue_item(ACT_LOAD, 32'h8000_0000);
      queue_item(ACT_LOAD, 32'h7FFF_FFFF);
      queue_item(ACT_LOAD, 32'h0000_0000);
      queue_item(ACT_LOAD, 32'h0000_0000);
      queue_item(ACT_LOAD, 32'h1234_5678);
      repeat (6) queue_item(ACT_PULL, 32'hA5A5_5A5A);
      queue_item(ACT_PULL, 32'h5A5A_A5A5);
      queue_item(ACT_LOAD, 32'h5A5A_A5A5);

      // saturating extremes, full-size store, with a mid-batch drain
      run_phase(31, 127, 1'b1, 1'b1, 1'b1, 1'b0);
      run_phase(0, 0, 1'b1, 1'b1, 1'b0, 1'b0);
      run_phase(16, 1, 1'b1, 1'b1, 1'b0, 1'b0);
      run_phase(1, 65, 1'b1, 1'b1, 1'b0, 1'b0);

      restart_due = 1'b0;
      while (queued_items < ITEM_BUDGET) begin
         sel = $urandom_range(0, 19);
         if (sel == 0) runs = 0;
         else if (sel == 1) runs = $urandom_range(17, 31);
         else if (sel < 5) runs = $urandom_range(9, 16);
         else runs = $urandom_range(1, 8);
         sel = $urandom_range(0, 19);
         if (sel == 0) len = 0;
         else if (sel == 1) begin
            len = $urandom_range(65, 127);
            runs = $urandom_range(1, 2);
         end else if (sel < 4) len = $urandom_range(9, 24);
         else len = $urandom_range(1, 8);
         set_runs = restart_due || ($urandom_range(0, 3) != 0);
         set_len = ($urandom_range(0, 3) != 0);
         abort = ($urandom_range(0, 11) == 0);
         run_phase(runs, len, set_runs, set_len, 1'b0, abort);
         restart_due = abort;
      end

      wait_idle();
      repeat (20) @(posedge clock);
      $display("covered %0d loads, %0d pulls, %0d merged batches, %0d register writes",
               loads_accepted, pulls_accepted, batches_merged, csr_writes);
      $display("responses: %0d ok, %0d dropped loads, %0d early pulls; %0d mismatches",
               ok_count, full_count, empty_count, mismatches);
      if (mismatches == 0 && pending_merge_out.size() == 0) begin
         $display("[pairwise_kway_merge_tree] OK");
      end else begin
         $display("[pairwise_kway_merge_tree] ERROR");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/pkmt_pkg.sv
rtl/pkmt_ctrl.sv
rtl/pkmt_dpath.sv
rtl/pairwise_kway_merge_tree.sv
test/testbench.sv
